[rtl/efc_pkg.sv]
package efc_pkg;

    // Fixed-point constants.
    localparam int unsigned ONE_Q16 = 65536;
    localparam logic [31:0] MAX32   = 32'hFFFF_FFFF;

    // Serial unit geometry: a 49-bit dividend (a 32-bit value shifted up by 16,
    // or 2^32) and a 32-bit multiplier scanned one bit per cycle.
    localparam int unsigned NUM_W     = 49;
    localparam int unsigned ACC_W     = 66;
    localparam int unsigned CNT_W     = 6;
    localparam int unsigned DIV_STEPS = NUM_W;
    localparam int unsigned MAC_STEPS = 32;

    // Band limits fit in 25 bits: an offset of up to 2^24 - 1 plus one.
    localparam int unsigned BAND_W = 25;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_D_RATE  = 2'd0;
    localparam logic [1:0] REG_L_RATE  = 2'd1;
    localparam logic [1:0] REG_R_LOWER = 2'd2;
    localparam logic [1:0] REG_R_UPPER = 2'd3;

    // Register reset values.
    localparam logic [15:0] RST_D_RATE  = 16'd65470;
    localparam logic [15:0] RST_L_RATE  = 16'd65470;
    localparam logic [23:0] RST_R_LOWER = 24'd6554;
    localparam logic [23:0] RST_R_UPPER = 24'd655360;

    // Result status codes.
    localparam logic [1:0] ST_UPDATED = 2'd0;
    localparam logic [1:0] ST_INIT    = 2'd1;
    localparam logic [1:0] ST_HELD    = 2'd2;

    typedef enum logic {
        OP_DIV = 1'b0,
        OP_MAC = 1'b1
    } t_op;

    // Launch of one operation on the shared serial unit.
    typedef struct packed {
        logic              start;
        t_op               op;
        logic [NUM_W-1:0]  num;
        logic [31:0]       den;
        logic [31:0]       x;
        logic [31:0]       y;
        logic [31:0]       ma;
        logic [31:0]       mb;
    } t_unit_req;

    typedef struct packed {
        logic              done;
        logic [NUM_W-1:0]  quot;
        logic [ACC_W-1:0]  prod;
    } t_unit_rsp;

    typedef enum logic [9:0] {
        S_IDLE   = 10'b00_0000_0001,
        S_CHECK  = 10'b00_0000_0010,
        S_DIVLO  = 10'b00_0000_0100,
        S_DIVHI  = 10'b00_0000_1000,
        S_DIVQ   = 10'b00_0001_0000,
        S_MULT   = 10'b00_0010_0000,
        S_BLENDS = 10'b00_0100_0000,
        S_DIVR   = 10'b00_1000_0000,
        S_BLENDD = 10'b01_0000_0000,
        S_FIN    = 10'b10_0000_0000
    } t_state;

endpackage

[rtl/efc_serial_unit.sv]
// Shared bit-serial arithmetic: restoring division (one quotient bit per cycle)
// and a right-shifting multiply-accumulate of x*ma + y*mb (one multiplier bit
// of each per cycle).
module efc_serial_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  efc_pkg::t_unit_req   i_req,
    output efc_pkg::t_unit_rsp   o_rsp
);

    logic                         r_busy;
    logic                         r_done;
    efc_pkg::t_op                 r_op;
    logic [efc_pkg::CNT_W-1:0]    r_cnt;
    logic [efc_pkg::NUM_W-1:0]    r_num;
    logic [31:0]                  r_rem;
    logic [31:0]                  r_den;
    logic [31:0]                  r_x;
    logic [31:0]                  r_y;
    logic [31:0]                  r_ma;
    logic [31:0]                  r_mb;
    logic [efc_pkg::ACC_W-1:0]    r_acc;

    logic [32:0]                  w_trial;
    logic [33:0]                  w_sub;
    logic                         w_qbit;
    logic [31:0]                  n_rem;
    logic [32:0]                  w_add;
    logic [34:0]                  w_sum;
    logic [efc_pkg::ACC_W-1:0]    n_acc;
    logic [efc_pkg::CNT_W-1:0]    w_last;

    always_comb begin
        // Division step: bring down the next dividend bit and try the divisor.
        w_trial = {r_rem, r_num[efc_pkg::NUM_W-1]};
        w_sub   = {1'b0, w_trial} - {2'b00, r_den};
        w_qbit  = ~w_sub[33];
        n_rem   = w_qbit ? w_sub[31:0] : w_trial[31:0];

        // Multiply step: add the selected multiplicands, then shift right.
        w_add = (r_ma[0] ? {1'b0, r_x} : 33'd0) + (r_mb[0] ? {1'b0, r_y} : 33'd0);
        w_sum = {1'b0, r_acc[efc_pkg::ACC_W-1:32]} + {2'b00, w_add};
        n_acc = {w_sum, r_acc[31:1]};

        w_last = (r_op == efc_pkg::OP_DIV) ? efc_pkg::CNT_W'(efc_pkg::DIV_STEPS - 1)
                                           : efc_pkg::CNT_W'(efc_pkg::MAC_STEPS - 1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == w_last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_op  <= i_req.op;
            r_num <= i_req.num;
            r_rem <= '0;
            r_den <= i_req.den;
            r_x   <= i_req.x;
            r_y   <= i_req.y;
            r_ma  <= i_req.ma;
            r_mb  <= i_req.mb;
            r_acc <= '0;
        end else if (r_busy) begin
            if (r_op == efc_pkg::OP_DIV) begin
                r_num <= {r_num[efc_pkg::NUM_W-2:0], w_qbit};
                r_rem <= n_rem;
            end else begin
                r_acc <= n_acc;
                r_ma  <= {1'b0, r_ma[31:1]};
                r_mb  <= {1'b0, r_mb[31:1]};
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_num;
    assign o_rsp.prod = r_acc;

endmodule

[rtl/eve_feedback_coefficient.sv]
// Work: an initializing or held request uses no arithmetic; an update runs D 49-step
//   divisions (1 to 4) and three 32-step MACs.
// Requests: one at a time on the shared bit-serial unit; a new request is accepted
//   once the result appears, even while the output is still stalled.
// Reset (synchronous, active low) clears the stored losses, d and the output valid flag
//   and loads the register reset values.
module eve_feedback_coefficient (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // Input stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] loss_value
    input  logic [0:0]  s_axis_tuser,   // [0] first_step

    // Result stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [95:0] m_axis_tdata,   // [31:0] clipped_loss, [63:32] smoothed_loss,
                                        // [95:64] feedback_d
    output logic [1:0]  m_axis_tuser,   // [1:0] status

    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // ------------------------------------------------------------------
    // Configuration registers. A write lands on the access cycle.
    // ------------------------------------------------------------------
    logic [15:0] r_cfg_d_rate;
    logic [15:0] r_cfg_l_rate;
    logic [23:0] r_cfg_lower;
    logic [23:0] r_cfg_upper;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_d_rate <= efc_pkg::RST_D_RATE;
            r_cfg_l_rate <= efc_pkg::RST_L_RATE;
            r_cfg_lower  <= efc_pkg::RST_R_LOWER;
            r_cfg_upper  <= efc_pkg::RST_R_UPPER;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[3:2])
                efc_pkg::REG_D_RATE:  r_cfg_d_rate <= pwdata[15:0];
                efc_pkg::REG_L_RATE:  r_cfg_l_rate <= pwdata[15:0];
                efc_pkg::REG_R_LOWER: r_cfg_lower  <= pwdata[23:0];
                efc_pkg::REG_R_UPPER: r_cfg_upper  <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            efc_pkg::REG_D_RATE:  prdata = {16'd0, r_cfg_d_rate};
            efc_pkg::REG_L_RATE:  prdata = {16'd0, r_cfg_l_rate};
            efc_pkg::REG_R_LOWER: prdata = {8'd0, r_cfg_lower};
            efc_pkg::REG_R_UPPER: prdata = {8'd0, r_cfg_upper};
            default:              prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer state and working registers.
    // ------------------------------------------------------------------
    efc_pkg::t_state                r_state, n_state;
    logic [31:0]                    r_prev, n_prev;
    logic [31:0]                    r_smooth, n_smooth;
    logic [31:0]                    r_coef, n_coef;
    logic [31:0]                    r_loss, n_loss;
    logic                           r_first, n_first;
    logic [efc_pkg::BAND_W-1:0]     r_lo, n_lo;
    logic [efc_pkg::BAND_W-1:0]     r_hi, n_hi;
    logic [31:0]                    r_tn, n_tn;
    logic [31:0]                    r_sn, n_sn;
    logic [1:0]                     r_status, n_status;
    logic                           r_out_valid, n_out_valid;
    logic [95:0]                    r_out_data, n_out_data;
    logic [1:0]                     r_out_user, n_out_user;

    efc_pkg::t_unit_req             w_req;
    efc_pkg::t_unit_rsp             w_rsp;

    logic [efc_pkg::NUM_W-1:0]      w_c1;
    logic [efc_pkg::BAND_W-1:0]     w_c;
    logic [31:0]                    w_tn;
    logic [31:0]                    w_m;
    logic [31:0]                    w_diff;
    logic [31:0]                    w_rq;
    logic [31:0]                    w_r;
    logic [16:0]                    w_l_weight;
    logic [16:0]                    w_d_weight;
    logic [efc_pkg::BAND_W-1:0]     w_lower1;
    logic [efc_pkg::BAND_W-1:0]     w_upper1;
    logic [efc_pkg::NUM_W-1:0]      w_q_num;
    logic [efc_pkg::NUM_W-1:0]      w_two32;

    efc_serial_unit u_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    always_comb begin
        // Offsets turned into ratio limits: k + 1 and K + 1 in Q16.16.
        w_lower1   = efc_pkg::BAND_W'(r_cfg_lower) + efc_pkg::BAND_W'(efc_pkg::ONE_Q16);
        w_upper1   = efc_pkg::BAND_W'(r_cfg_upper) + efc_pkg::BAND_W'(efc_pkg::ONE_Q16);
        w_l_weight = 17'(efc_pkg::ONE_Q16) - {1'b0, r_cfg_l_rate};
        w_d_weight = 17'(efc_pkg::ONE_Q16) - {1'b0, r_cfg_d_rate};
        w_two32    = efc_pkg::NUM_W'(1) << 32;
        w_q_num    = {1'b0, r_loss, 16'd0};

        // Clamp of the ratio; the upper limit wins when the band is inverted.
        w_c1 = (w_rsp.quot < efc_pkg::NUM_W'(r_lo)) ? efc_pkg::NUM_W'(r_lo) : w_rsp.quot;
        w_c  = (w_c1 > efc_pkg::NUM_W'(r_hi)) ? r_hi : w_c1[efc_pkg::BAND_W-1:0];

        // New clipped loss from c * P / 2^16, saturated to 32 bits.
        w_tn = (|w_rsp.prod[efc_pkg::ACC_W-1:48]) ? efc_pkg::MAX32 : w_rsp.prod[47:16];
        w_m  = (w_tn < r_prev) ? w_tn : r_prev;

        w_diff = (r_tn > r_prev) ? (r_tn - r_prev) : (r_prev - r_tn);
        w_rq   = (|w_rsp.quot[efc_pkg::NUM_W-1:32]) ? efc_pkg::MAX32 : w_rsp.quot[31:0];
        // With a zero smoothed loss the divide is skipped and r saturates
        // unless the clipped loss did not move.
        w_r = (r_state == efc_pkg::S_DIVR) ? w_rq
                                           : ((w_diff == 32'd0) ? 32'd0 : efc_pkg::MAX32);
    end

    always_comb begin
        n_state     = r_state;
        n_prev      = r_prev;
        n_smooth    = r_smooth;
        n_coef      = r_coef;
        n_loss      = r_loss;
        n_first     = r_first;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_tn        = r_tn;
        n_sn        = r_sn;
        n_status    = r_status;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        n_out_user  = r_out_user;

        w_req       = '0;
        w_req.op    = efc_pkg::OP_DIV;

        if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            efc_pkg::S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_loss  = s_axis_tdata;
                    n_first = s_axis_tuser[0];
                    n_state = efc_pkg::S_CHECK;
                end
            end
            efc_pkg::S_CHECK: begin
                if (r_first || (r_prev == 32'd0)) begin
                    // A negative loss loads as zero, so the next request
                    // initializes again.
                    n_prev   = r_loss[31] ? 32'd0 : r_loss;
                    n_smooth = r_loss[31] ? 32'd0 : r_loss;
                    n_coef   = 32'(efc_pkg::ONE_Q16);
                    n_status = efc_pkg::ST_INIT;
                    n_state  = efc_pkg::S_FIN;
                end else if (r_loss[31]) begin
                    n_status = efc_pkg::ST_HELD;
                    n_state  = efc_pkg::S_FIN;
                end else if (r_loss > r_prev) begin
                    n_lo       = w_lower1;
                    n_hi       = w_upper1;
                    w_req.start = 1'b1;
                    w_req.num   = w_q_num;
                    w_req.den   = r_prev;
                    n_state     = efc_pkg::S_DIVQ;
                end else begin
                    // Falling or unchanged loss: the band is the reciprocal of the rising one.
                    w_req.start = 1'b1;
                    w_req.num   = w_two32;
                    w_req.den   = 32'(w_upper1);
                    n_state     = efc_pkg::S_DIVLO;
                end
            end
            efc_pkg::S_DIVLO: begin
                if (w_rsp.done) begin
                    n_lo        = w_rsp.quot[efc_pkg::BAND_W-1:0];
                    w_req.start = 1'b1;
                    w_req.num   = w_two32;
                    w_req.den   = 32'(w_lower1);
                    n_state     = efc_pkg::S_DIVHI;
                end
            end
            efc_pkg::S_DIVHI: begin
                if (w_rsp.done) begin
                    n_hi        = w_rsp.quot[efc_pkg::BAND_W-1:0];
                    w_req.start = 1'b1;
                    w_req.num   = w_q_num;
                    w_req.den   = r_prev;
                    n_state     = efc_pkg::S_DIVQ;
                end
            end
            efc_pkg::S_DIVQ: begin
                if (w_rsp.done) begin
                    w_req.start = 1'b1;
                    w_req.op    = efc_pkg::OP_MAC;
                    w_req.x     = r_prev;
                    w_req.ma    = 32'(w_c);
                    n_state     = efc_pkg::S_MULT;
                end
            end
            efc_pkg::S_MULT: begin
                if (w_rsp.done) begin
                    n_tn        = w_tn;
                    w_req.start = 1'b1;
                    w_req.op    = efc_pkg::OP_MAC;
                    w_req.x     = r_smooth;
                    w_req.ma    = 32'(r_cfg_l_rate);
                    w_req.y     = w_m;
                    w_req.mb    = 32'(w_l_weight);
                    n_state     = efc_pkg::S_BLENDS;
                end
            end
            efc_pkg::S_BLENDS: begin
                if (w_rsp.done) begin
                    n_sn = w_rsp.prod[47:16];
                    w_req.start = 1'b1;
                    if (w_rsp.prod[47:16] == 32'd0) begin
                        w_req.op = efc_pkg::OP_MAC;
                        w_req.x  = r_coef;
                        w_req.ma = 32'(r_cfg_d_rate);
                        w_req.y  = w_r;
                        w_req.mb = 32'(w_d_weight);
                        n_state  = efc_pkg::S_BLENDD;
                    end else begin
                        w_req.num = {1'b0, w_diff, 16'd0};
                        w_req.den = w_rsp.prod[47:16];
                        n_state   = efc_pkg::S_DIVR;
                    end
                end
            end
            efc_pkg::S_DIVR: begin
                if (w_rsp.done) begin
                    w_req.start = 1'b1;
                    w_req.op    = efc_pkg::OP_MAC;
                    w_req.x     = r_coef;
                    w_req.ma    = 32'(r_cfg_d_rate);
                    w_req.y     = w_r;
                    w_req.mb    = 32'(w_d_weight);
                    n_state     = efc_pkg::S_BLENDD;
                end
            end
            efc_pkg::S_BLENDD: begin
                if (w_rsp.done) begin
                    n_coef   = w_rsp.prod[47:16];
                    n_prev   = r_tn;
                    n_smooth = r_sn;
                    n_status = efc_pkg::ST_UPDATED;
                    n_state  = efc_pkg::S_FIN;
                end
            end
            efc_pkg::S_FIN: begin
                // The result moves to the output register once it is free.
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {r_coef, r_smooth, r_prev};
                    n_out_user  = r_status;
                    n_state     = efc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = efc_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= efc_pkg::S_IDLE;
            r_prev      <= '0;
            r_smooth    <= '0;
            r_coef      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_prev      <= n_prev;
            r_smooth    <= n_smooth;
            r_coef      <= n_coef;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_loss     <= n_loss;
        r_first    <= n_first;
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_tn       <= n_tn;
        r_sn       <= n_sn;
        r_status   <= n_status;
        r_out_data <= n_out_data;
        r_out_user <= n_out_user;
    end

    assign s_axis_tready = (r_state == efc_pkg::S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_accept_to_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (r_state == efc_pkg::S_CHECK))
        else $error("accepted request did not move to the check step");

    a_fin_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == efc_pkg::S_FIN && r_out_valid && !m_axis_tready)
        |=> (r_state == efc_pkg::S_FIN && $stable(r_out_data)))
        else $error("pending result overwritten by the next one");

    a_done_in_compute: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp.done |-> (r_state == efc_pkg::S_DIVLO || r_state == efc_pkg::S_DIVHI ||
                        r_state == efc_pkg::S_DIVQ  || r_state == efc_pkg::S_MULT  ||
                        r_state == efc_pkg::S_BLENDS || r_state == efc_pkg::S_DIVR ||
                        r_state == efc_pkg::S_BLENDD))
        else $error("serial unit finished outside a compute step");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser == efc_pkg::ST_UPDATED ||
                           m_axis_tuser == efc_pkg::ST_INIT ||
                           m_axis_tuser == efc_pkg::ST_HELD))
        else $error("result carries an unknown status");

endmodule
